>>> sv/tdbd_pkg.sv
// ----------------------------------------------------------------------------
// tdbd_pkg
// Shared widths, codes and stage types of the twist to dual bridge drive core.
// ----------------------------------------------------------------------------
package tdbd_pkg;

    // command and register widths
    localparam int CMD_BITS      = 16;
    localparam int HW_BITS       = 15;
    localparam int DB_BITS       = 13;
    localparam int MASK_BITS     = 4;
    localparam int CFG_DATA_BITS = 15;
    localparam int CFG_IDX_BITS  = 2;

    // duty resolution
    localparam int DUTY_BITS = 10;
    localparam logic [DUTY_BITS-1:0] DUTY_FULL = {DUTY_BITS{1'b1}};

    // wheel value formats: signed q.24 in 32 bits, magnitude in 31 bits
    localparam int WHEEL_BITS = 32;
    localparam int MAG_BITS   = 31;
    localparam int FRAC_BITS  = 24;
    localparam int QBITS      = FRAC_BITS + 1;
    localparam int DB_SHIFT   = 12;

    localparam logic [MAG_BITS-1:0] ONE_Q24 =
        {{(MAG_BITS-QBITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    // bridge pin codes, first pin in the upper bit
    localparam logic [1:0] PINS_STOP = 2'b00;
    localparam logic [1:0] PINS_FWD  = 2'b10;
    localparam logic [1:0] PINS_BACK = 2'b01;

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_HALF_WHEELBASE = 2'd0,
        CFG_DEADBAND       = 2'd1,
        CFG_REVERSE_MASK   = 2'd2
    } cfg_index_t;

    // one wheel after mixing: sign, magnitude and divisor
    typedef struct packed {
        logic                neg;
        logic [MAG_BITS-1:0] mag;
        logic [MAG_BITS-1:0] div;
    } tdbd_wheel_in_t;

    // one divider stage: partial remainder and quotient
    typedef struct packed {
        logic                neg;
        logic [MAG_BITS-1:0] rem;
        logic [QBITS-1:0]    quo;
        logic [MAG_BITS-1:0] div;
    } tdbd_div_t;

endpackage

>>> sv/tdbd_mix.sv
// ----------------------------------------------------------------------------
// tdbd_mix
// Four stage mixer for one command pair: product, sum and difference,
// magnitudes, then the larger magnitude clamped below at one as divisor.
// ----------------------------------------------------------------------------
module tdbd_mix
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [tdbd_pkg::CMD_BITS-1:0] a,
    input  logic signed [tdbd_pkg::CMD_BITS-1:0] b,
    input  logic [tdbd_pkg::HW_BITS-1:0]         half_wheelbase,
    output logic                                out_valid,
    output tdbd_pkg::tdbd_wheel_in_t            out_l,
    output tdbd_pkg::tdbd_wheel_in_t            out_r
);

    localparam int WB = tdbd_pkg::WHEEL_BITS;
    localparam int MB = tdbd_pkg::MAG_BITS;
    localparam int CB = tdbd_pkg::CMD_BITS;

    logic [3:0] valid_reg;

    logic signed [WB-1:0] base_reg;
    logic signed [WB-1:0] turn_reg;
    logic signed [WB-1:0] lv_reg;
    logic signed [WB-1:0] rv_reg;
    logic                 neg_l_reg;
    logic                 neg_r_reg;
    logic [MB-1:0]        mag_l_reg;
    logic [MB-1:0]        mag_r_reg;
    tdbd_pkg::tdbd_wheel_in_t out_l_reg;
    tdbd_pkg::tdbd_wheel_in_t out_r_reg;

    logic signed [WB-1:0] base_next;
    logic signed [WB-1:0] turn_next;
    logic [WB-1:0]        lv_neg;
    logic [WB-1:0]        rv_neg;
    logic [MB-1:0]        mag_l_next;
    logic [MB-1:0]        mag_r_next;
    logic [MB-1:0]        mx;
    logic [MB-1:0]        div_next;

    // stage one: base in q.24 and turn product
    always_comb
    begin
        base_next = {{(WB-CB-12){a[CB-1]}}, a, 12'b0};
        turn_next = WB'(b) * WB'($signed({1'b0, half_wheelbase}));
    end

    // stage three: magnitudes
    always_comb
    begin
        lv_neg     = '0 - lv_reg;
        rv_neg     = '0 - rv_reg;
        mag_l_next = lv_reg[WB-1] ? lv_neg[MB-1:0] : lv_reg[MB-1:0];
        mag_r_next = rv_reg[WB-1] ? rv_neg[MB-1:0] : rv_reg[MB-1:0];
    end

    // stage four: divisor is the larger magnitude, at least one
    always_comb
    begin
        mx       = (mag_l_reg > mag_r_reg) ? mag_l_reg : mag_r_reg;
        div_next = (mx > tdbd_pkg::ONE_Q24) ? mx : tdbd_pkg::ONE_Q24;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        turn_reg      <= turn_next;
        lv_reg        <= base_reg + turn_reg;
        rv_reg        <= base_reg - turn_reg;
        neg_l_reg     <= lv_reg[WB-1];
        neg_r_reg     <= rv_reg[WB-1];
        mag_l_reg     <= mag_l_next;
        mag_r_reg     <= mag_r_next;
        out_l_reg.neg <= neg_l_reg;
        out_l_reg.mag <= mag_l_reg;
        out_l_reg.div <= div_next;
        out_r_reg.neg <= neg_r_reg;
        out_r_reg.mag <= mag_r_reg;
        out_r_reg.div <= div_next;
    end

    assign out_valid = valid_reg[3];
    assign out_l     = out_l_reg;
    assign out_r     = out_r_reg;

endmodule

>>> sv/tdbd_div_step.sv
// ----------------------------------------------------------------------------
// tdbd_div_step
// One registered restoring division step: shift in a bit, compare, subtract.
// ----------------------------------------------------------------------------
module tdbd_div_step
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  tdbd_pkg::tdbd_div_t in_stage,
    input  logic                in_lsb,
    output logic                out_valid,
    output tdbd_pkg::tdbd_div_t out_stage
);

    localparam int MB = tdbd_pkg::MAG_BITS;
    localparam int QB = tdbd_pkg::QBITS;

    logic                valid_reg;
    tdbd_pkg::tdbd_div_t stage_reg;
    tdbd_pkg::tdbd_div_t stage_next;

    logic [MB:0] trial;
    logic [MB:0] diff;
    logic        ge;

    // trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        trial          = {in_stage.rem, in_lsb};
        diff           = trial - {1'b0, in_stage.div};
        ge             = (trial >= {1'b0, in_stage.div});
        stage_next.neg = in_stage.neg;
        stage_next.div = in_stage.div;
        stage_next.rem = ge ? diff[MB-1:0] : trial[MB-1:0];
        stage_next.quo = {in_stage.quo[QB-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

>>> sv/tdbd_wheel.sv
// ----------------------------------------------------------------------------
// tdbd_wheel
// One wheel: pipelined normalizing divide, then bridge pins and pwm duty.
// ----------------------------------------------------------------------------
module tdbd_wheel
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  tdbd_pkg::tdbd_wheel_in_t          in_wheel,
    input  logic [tdbd_pkg::DB_BITS-1:0]      deadband,
    input  logic                              rev,
    output logic                              out_valid,
    output logic [1:0]                        pins,
    output logic [tdbd_pkg::DUTY_BITS-1:0]    duty
);

    localparam int MB = tdbd_pkg::MAG_BITS;
    localparam int QB = tdbd_pkg::QBITS;
    localparam int DB = tdbd_pkg::DUTY_BITS;
    localparam int FB = tdbd_pkg::FRAC_BITS;

    logic                valid_chain [0:QB];
    tdbd_pkg::tdbd_div_t stage_chain [0:QB];
    logic [QB-1:0]       lsb;

    logic          valid_reg;
    logic [1:0]    pins_reg;
    logic [DB-1:0] duty_reg;
    logic [1:0]    pins_next;
    logic [DB-1:0] duty_next;

    logic [QB-1:0]    quo;
    logic [QB+DB-1:0] prod;
    logic [QB-1:0]    thr;
    logic             stop;

    // first step sees the whole magnitude, later steps shift in zeros
    assign valid_chain[0] = in_valid;
    assign stage_chain[0] = {in_wheel.neg, {1'b0, in_wheel.mag[MB-1:1]}, {QB{1'b0}},
                             in_wheel.div};
    assign lsb            = {{(QB-1){1'b0}}, in_wheel.mag[0]};

    // one quotient bit per stage
    for (genvar i = 0; i < QB; i++)
    begin : g_step
        tdbd_div_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_chain[i]),
            .in_stage  (stage_chain[i]),
            .in_lsb    (lsb[i]),
            .out_valid (valid_chain[i+1]),
            .out_stage (stage_chain[i+1])
        );
    end

    // deadband, direction and duty
    always_comb
    begin
        quo       = stage_chain[QB].quo;
        prod      = (QB+DB)'(quo) * (QB+DB)'(tdbd_pkg::DUTY_FULL);
        duty_next = prod[FB+DB-1:FB];
        thr       = {deadband, {tdbd_pkg::DB_SHIFT{1'b0}}};
        stop      = (quo <= thr);
        priority if (stop)
        begin
            pins_next = tdbd_pkg::PINS_STOP;
        end
        else if (stage_chain[QB].neg ^ rev)
        begin
            pins_next = tdbd_pkg::PINS_BACK;
        end
        else
        begin
            pins_next = tdbd_pkg::PINS_FWD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_chain[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        pins_reg <= pins_next;
        duty_reg <= duty_next;
    end

    assign out_valid = valid_reg;
    assign pins      = pins_reg;
    assign duty      = duty_reg;

endmodule

>>> sv/twist_to_dual_bridge_drive_core.sv
// ----------------------------------------------------------------------------
// twist_to_dual_bridge_drive_core
// Pipeline from start to done: 4 mixer stages, 25 divide stages
// (one quotient bit each) and one output stage.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// Reset: rst_n clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module twist_to_dual_bridge_drive_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [tdbd_pkg::CMD_BITS-1:0]  linear_speed,
    input  logic signed [tdbd_pkg::CMD_BITS-1:0]  yaw_rate,
    input  logic signed [tdbd_pkg::CMD_BITS-1:0]  roll_rate,
    input  logic signed [tdbd_pkg::CMD_BITS-1:0]  pitch_rate,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tdbd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [tdbd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output logic                                  done,
    output logic [1:0]                            left_pins,
    output logic [1:0]                            right_pins,
    output logic [1:0]                            inner_left_pins,
    output logic [1:0]                            inner_right_pins,
    output logic [tdbd_pkg::DUTY_BITS-1:0]        left_duty,
    output logic [tdbd_pkg::DUTY_BITS-1:0]        right_duty,
    output logic [tdbd_pkg::DUTY_BITS-1:0]        inner_left_duty,
    output logic [tdbd_pkg::DUTY_BITS-1:0]        inner_right_duty
);

    logic [tdbd_pkg::HW_BITS-1:0]   half_wheelbase_reg;
    logic [tdbd_pkg::DB_BITS-1:0]   deadband_reg;
    logic [tdbd_pkg::MASK_BITS-1:0] reverse_mask_reg;

    logic accept;
    logic outer_valid;
    logic inner_valid;
    logic [3:0] wheel_valid;

    tdbd_pkg::tdbd_wheel_in_t l_mix;
    tdbd_pkg::tdbd_wheel_in_t r_mix;
    tdbd_pkg::tdbd_wheel_in_t il_mix;
    tdbd_pkg::tdbd_wheel_in_t ir_mix;

    // handshakes: the pipeline never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_wheelbase_reg <= 15'd1024;
            deadband_reg       <= 13'd41;
            reverse_mask_reg   <= 4'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tdbd_pkg::CFG_HALF_WHEELBASE:
                begin
                    half_wheelbase_reg <= cfg_data[tdbd_pkg::HW_BITS-1:0];
                end
                tdbd_pkg::CFG_DEADBAND:
                begin
                    deadband_reg <= cfg_data[tdbd_pkg::DB_BITS-1:0];
                end
                tdbd_pkg::CFG_REVERSE_MASK:
                begin
                    reverse_mask_reg <= cfg_data[tdbd_pkg::MASK_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // outer pair mixer
    tdbd_mix u_mix_outer
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (accept),
        .a              (linear_speed),
        .b              (yaw_rate),
        .half_wheelbase (half_wheelbase_reg),
        .out_valid      (outer_valid),
        .out_l          (l_mix),
        .out_r          (r_mix)
    );

    // inner pair mixer
    tdbd_mix u_mix_inner
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (accept),
        .a              (pitch_rate),
        .b              (roll_rate),
        .half_wheelbase (half_wheelbase_reg),
        .out_valid      (inner_valid),
        .out_l          (il_mix),
        .out_r          (ir_mix)
    );

    // per wheel normalize and drive
    tdbd_wheel u_wheel_left
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (outer_valid),
        .in_wheel  (l_mix),
        .deadband  (deadband_reg),
        .rev       (reverse_mask_reg[0]),
        .out_valid (wheel_valid[0]),
        .pins      (left_pins),
        .duty      (left_duty)
    );

    tdbd_wheel u_wheel_right
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (outer_valid),
        .in_wheel  (r_mix),
        .deadband  (deadband_reg),
        .rev       (reverse_mask_reg[1]),
        .out_valid (wheel_valid[1]),
        .pins      (right_pins),
        .duty      (right_duty)
    );

    tdbd_wheel u_wheel_inner_left
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (inner_valid),
        .in_wheel  (il_mix),
        .deadband  (deadband_reg),
        .rev       (reverse_mask_reg[2]),
        .out_valid (wheel_valid[2]),
        .pins      (inner_left_pins),
        .duty      (inner_left_duty)
    );

    tdbd_wheel u_wheel_inner_right
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (inner_valid),
        .in_wheel  (ir_mix),
        .deadband  (deadband_reg),
        .rev       (reverse_mask_reg[3]),
        .out_valid (wheel_valid[3]),
        .pins      (inner_right_pins),
        .duty      (inner_right_duty)
    );

    // all four wheels finish together
    assign done = &wheel_valid;

endmodule

>>> sv/tdbd_checker.sv
// ----------------------------------------------------------------------------
// tdbd_checker
// Port level checks of the drive core, bound to the top level.
// ----------------------------------------------------------------------------
module tdbd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       cfg_ready,
    input logic       done,
    input logic [1:0] left_pins,
    input logic [1:0] right_pins,
    input logic [1:0] inner_left_pins,
    input logic [1:0] inner_right_pins
);

    localparam int LATENCY = 30;

    // the pipeline never holds off an item
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // configuration writes are always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg_ready dropped");

    // every result comes from an item taken a fixed latency earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching item");

    // both bridge inputs are never driven high together
    a_pins_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (left_pins != 2'b11) && (right_pins != 2'b11) &&
                 (inner_left_pins != 2'b11) && (inner_right_pins != 2'b11))
        else $error("illegal bridge pin code");

endmodule

bind twist_to_dual_bridge_drive_core tdbd_checker u_tdbd_checker (.*);

>>> sim/tb_twist_to_dual_bridge_drive_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_twist_to_dual_bridge_drive_core
// Self-checking bench for the drive mixer: directed corner items, then bursts of
// random commands under several register settings, each result checked field by
// field against a bit-accurate Q.24 mixing and normalization predictor.
// ----------------------------------------------------------------------------
module tb_twist_to_dual_bridge_drive_core;

    import tdbd_pkg::*;

    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     DRAIN_CYCLES = 40;
    localparam longint UNITY_Q24    = 64'sd16777216;
    localparam int     UNITY_Q12    = 4096;

    // spare register index, writes to it are dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 2'd3;

    // motor slots in the result vectors
    localparam int MOTOR_LEFT        = 0;
    localparam int MOTOR_RIGHT       = 1;
    localparam int MOTOR_INNER_LEFT  = 2;
    localparam int MOTOR_INNER_RIGHT = 3;

    typedef struct packed {
        logic signed [CMD_BITS-1:0] lin;
        logic signed [CMD_BITS-1:0] yaw;
        logic signed [CMD_BITS-1:0] roll;
        logic signed [CMD_BITS-1:0] pitch;
    } drive_cmd_t;

    typedef struct packed {
        logic [3:0][1:0]           pins;
        logic [3:0][DUTY_BITS-1:0] duty;
    } wheel_set_t;

    // mixer predictor and queue of pending wheel sets
    class drive_scoreboard;
        logic [HW_BITS-1:0]   half_wheelbase = 15'd1024;
        logic [DB_BITS-1:0]   deadband       = 13'd41;
        logic [MASK_BITS-1:0] reverse_mask   = 4'd10;
        wheel_set_t           wheel_q[$];
        int                   errors;
        int                   checked;
        int                   normalized;
        int                   stopped;
        int                   stopped_duty;

        function int pending();
            return wheel_q.size();
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_HALF_WHEELBASE: half_wheelbase = data[HW_BITS-1:0];
                CFG_DEADBAND:       deadband       = data[DB_BITS-1:0];
                CFG_REVERSE_MASK:   reverse_mask   = data[MASK_BITS-1:0];
                default:            ;
            endcase
        endfunction

        // one pair into two q.24 wheel values, scaled down if above 1.0
        function void mix_pair(longint a, longint b, output longint lv, output longint rv);
            longint base_v;
            longint turn_v;
            longint ml;
            longint mr;
            longint mx;
            base_v = a * UNITY_Q12;
            turn_v = b * longint'(half_wheelbase);
            lv = base_v + turn_v;
            rv = base_v - turn_v;
            ml = (lv < 0) ? -lv : lv;
            mr = (rv < 0) ? -rv : rv;
            mx = (ml > mr) ? ml : mr;
            if (mx > UNITY_Q24)
            begin
                lv = (lv * UNITY_Q24) / mx;
                rv = (rv * UNITY_Q24) / mx;
                normalized++;
            end
        endfunction

        // bridge pins and duty for one wheel
        function void drive_wheel(longint v, int motor, inout wheel_set_t ws);
            longint m;
            longint duty_v;
            logic   rev;
            m      = (v < 0) ? -v : v;
            rev    = reverse_mask[motor];
            duty_v = (m * longint'(DUTY_FULL)) >>> FRAC_BITS;
            ws.duty[motor] = duty_v[DUTY_BITS-1:0];
            if (m <= (longint'(deadband) <<< DB_SHIFT))
            begin
                ws.pins[motor] = PINS_STOP;
                stopped++;
                if (duty_v != 0)
                    stopped_duty++;
            end
            else if (v >= 0)
                ws.pins[motor] = rev ? PINS_BACK : PINS_FWD;
            else
                ws.pins[motor] = rev ? PINS_FWD : PINS_BACK;
        endfunction

        function void note_cmd(drive_cmd_t c);
            wheel_set_t ws;
            longint     l;
            longint     r;
            longint     il;
            longint     ir;
            ws = '0;
            mix_pair(longint'(c.lin), longint'(c.yaw), l, r);
            mix_pair(longint'(c.pitch), longint'(c.roll), il, ir);
            drive_wheel(l, MOTOR_LEFT, ws);
            drive_wheel(r, MOTOR_RIGHT, ws);
            drive_wheel(il, MOTOR_INNER_LEFT, ws);
            drive_wheel(ir, MOTOR_INNER_RIGHT, ws);
            wheel_q.push_back(ws);
        endfunction

        function string motor_label(int m);
            case (m)
                MOTOR_LEFT:       return "left";
                MOTOR_RIGHT:      return "right";
                MOTOR_INNER_LEFT: return "inner left";
                default:          return "inner right";
            endcase
        endfunction

        function void check_result(wheel_set_t got);
            wheel_set_t want;
            if (wheel_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item outstanding, pins %h duty %h",
                         $time, got.pins, got.duty);
                return;
            end
            want = wheel_q.pop_front();
            checked++;
            for (int m = 0; m < 4; m++)
            begin
                if (got.pins[m] !== want.pins[m])
                begin
                    errors++;
                    $display("%0t: %s pins mismatch, expected %b, actual %b",
                             $time, motor_label(m), want.pins[m], got.pins[m]);
                end
                if (got.duty[m] !== want.duty[m])
                begin
                    errors++;
                    $display("%0t: %s duty mismatch, expected %0d, actual %0d",
                             $time, motor_label(m), want.duty[m], got.duty[m]);
                end
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [CMD_BITS-1:0]  linear_speed;
    logic signed [CMD_BITS-1:0]  yaw_rate;
    logic signed [CMD_BITS-1:0]  roll_rate;
    logic signed [CMD_BITS-1:0]  pitch_rate;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_BITS-1:0]     cfg_index;
    logic [CFG_DATA_BITS-1:0]    cfg_data;
    logic                        done;
    logic [1:0]                  left_pins;
    logic [1:0]                  right_pins;
    logic [1:0]                  inner_left_pins;
    logic [1:0]                  inner_right_pins;
    logic [DUTY_BITS-1:0]        left_duty;
    logic [DUTY_BITS-1:0]        right_duty;
    logic [DUTY_BITS-1:0]        inner_left_duty;
    logic [DUTY_BITS-1:0]        inner_right_duty;

    drive_scoreboard sb;
    int              cycles;
    int              settings_run;

    twist_to_dual_bridge_drive_core i_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .linear_speed     (linear_speed),
        .yaw_rate         (yaw_rate),
        .roll_rate        (roll_rate),
        .pitch_rate       (pitch_rate),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .left_pins        (left_pins),
        .right_pins       (right_pins),
        .inner_left_pins  (inner_left_pins),
        .inner_right_pins (inner_right_pins),
        .left_duty        (left_duty),
        .right_duty       (right_duty),
        .inner_left_duty  (inner_left_duty),
        .inner_right_duty (inner_right_duty)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d wheel sets outstanding",
                     cycles, sb.pending());
            $display("twist_to_dual_bridge_drive_core regression: fail");
            $finish;
        end
    end

    // record accepted items and check results
    always @(posedge clk)
    begin
        wheel_set_t got;
        drive_cmd_t c;
        if (rst_n)
        begin
            if (done)
            begin
                got.pins = {inner_right_pins, inner_left_pins, right_pins, left_pins};
                got.duty = {inner_right_duty, inner_left_duty, right_duty, left_duty};
                sb.check_result(got);
            end
            if (start && !busy)
            begin
                c = '{lin: linear_speed, yaw: yaw_rate, roll: roll_rate, pitch: pitch_rate};
                sb.note_cmd(c);
            end
        end
    end

    function automatic drive_cmd_t make_cmd(int lin, int yaw, int roll, int pitch);
        drive_cmd_t c;
        c.lin   = CMD_BITS'(lin);
        c.yaw   = CMD_BITS'(yaw);
        c.roll  = CMD_BITS'(roll);
        c.pitch = CMD_BITS'(pitch);
        return c;
    endfunction

    // one q4.12 value, weighted toward the interesting regions
    function automatic int rand_q412();
        int v;
        case ($urandom_range(0, 5))
            0: v = int'($signed(CMD_BITS'($urandom)));
            1: v = $urandom_range(0, 200);
            2: v = $urandom_range(UNITY_Q12 - 150, UNITY_Q12 + 150);
            3:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = 0;
                    default: v = UNITY_Q12;
                endcase
            end
            default: v = $urandom_range(0, 2 * UNITY_Q12);
        endcase
        if ($urandom_range(0, 1) == 1 && v > -32768)
            v = -v;
        return v;
    endfunction

    // present one item and hold it until accepted, start left high
    task automatic send_cmd(drive_cmd_t c);
        start        <= 1'b1;
        linear_speed <= c.lin;
        yaw_rate     <= c.yaw;
        roll_rate    <= c.roll;
        pitch_rate   <= c.pitch;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // gap with start low
    task automatic idle_gap(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // hold off until every outstanding wheel set has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // register write, valid stays high for a following write
    task automatic write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // new register setting once the pipe is empty, junk in the unused data bits
    task automatic configure(int hw, int db, int mask, bit spare_write);
        wait_drained();
        if (spare_write)
            write_cfg(CFG_UNMAPPED, CFG_DATA_BITS'($urandom));
        write_cfg(CFG_HALF_WHEELBASE, CFG_DATA_BITS'(hw));
        write_cfg(CFG_DEADBAND, {2'($urandom), DB_BITS'(db)});
        write_cfg(CFG_REVERSE_MASK, {11'($urandom), MASK_BITS'(mask)});
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // random items in bursts with random gaps and occasional drains
    task automatic run_random(int count);
        int burst_left;
        burst_left = $urandom_range(1, 16);
        for (int i = 0; i < count; i++)
        begin
            send_cmd(make_cmd(rand_q412(), rand_q412(), rand_q412(), rand_q412()));
            burst_left--;
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
                else
                    idle_gap($urandom_range(1, 12));
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 16);
            end
        end
        idle_gap(1);
    endtask

    // stimulus
    initial
    begin
        drive_cmd_t corner_items[$];
        int         hw;
        int         db;

        sb           = new();
        cycles       = 0;
        settings_run = 1;
        rst_n        = 1'b0;
        start        <= 1'b0;
        linear_speed <= '0;
        yaw_rate     <= '0;
        roll_rate    <= '0;
        pitch_rate   <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_HALF_WHEELBASE;
        cfg_data     <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners under the reset setting
        corner_items = '{
            make_cmd(0, 0, 0, 0),
            make_cmd(32767, 32767, 32767, 32767),
            make_cmd(-32768, -32768, -32768, -32768),
            make_cmd(32767, -32768, -32768, 32767),
            make_cmd(4096, 0, 0, 4096),
            make_cmd(4096, 1, 1, 4096),
            make_cmd(-4096, 0, 0, -4096),
            make_cmd(41, 0, 0, 41),
            make_cmd(42, 0, 0, -42),
            make_cmd(-41, 0, 0, -42),
            make_cmd(0, 4096, 4096, 0),
            make_cmd(0, -4096, -4096, 0),
            make_cmd(2048, 8192, -8192, 2048),
            make_cmd(16384, 0, 0, -16384),
            make_cmd(0, 32767, -32768, 0),
            make_cmd(1, 0, 0, -1)
        };
        foreach (corner_items[i])
            send_cmd(corner_items[i]);
        idle_gap(1);

        // zero turn scale, zero deadband, no reversal
        configure(0, 0, 0, 1'b0);
        send_cmd(make_cmd(0, 32767, -32768, 0));
        send_cmd(make_cmd(1, 0, 0, -1));
        send_cmd(make_cmd(-32768, 5, 5, 32767));
        idle_gap(1);

        // widest turn scale, deadband at 1.0, every motor reversed
        configure(32767, 4096, 15, 1'b0);
        send_cmd(make_cmd(4096, 0, 0, -4096));
        send_cmd(make_cmd(0, 1, -1, 0));
        send_cmd(make_cmd(100, -32768, 32767, -100));
        send_cmd(make_cmd(-32768, 32767, 0, 32767));
        idle_gap(1);

        // random settings with random items
        for (int ph = 0; ph < 6; ph++)
        begin
            case ($urandom_range(0, 4))
                0:       hw = 0;
                1:       hw = 32767;
                2:       hw = $urandom_range(1024, 8192);
                default: hw = $urandom_range(0, 32767);
            endcase
            case ($urandom_range(0, 5))
                0:       db = 0;
                1:       db = 4096;
                2:       db = (ph == 3) ? 8191 : 41;
                default: db = $urandom_range(0, 300);
            endcase
            configure(hw, db, $urandom_range(0, 15), ph == 2);
            run_random(80 + $urandom_range(0, 10));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d wheel sets checked over %0d register settings, %0d pairs normalized",
                 sb.checked, settings_run, sb.normalized);
        $display("%0d wheels stopped, %0d of them with a nonzero duty",
                 sb.stopped, sb.stopped_duty);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("twist_to_dual_bridge_drive_core regression: pass");
        else
            $display("twist_to_dual_bridge_drive_core regression: fail");
        $finish;
    end

endmodule

>>> files.f
sv/tdbd_pkg.sv
sv/tdbd_mix.sv
sv/tdbd_div_step.sv
sv/tdbd_wheel.sv
sv/twist_to_dual_bridge_drive_core.sv
sv/tdbd_checker.sv
sim/tb_twist_to_dual_bridge_drive_core.sv
